// ----- hw/rtl/obbov_pkg.sv -----
package obbov_pkg;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [49:0] proj_t;
  typedef logic [48:0]        pmag_t;
  typedef logic signed [32:0] dotc_t;
  typedef logic [31:0]        cmag_t;
  typedef logic [30:0]        half_t;
  typedef logic [62:0]        rprod_t;
  typedef logic signed [57:0] lpart_t;
  typedef logic signed [81:0] eprod_t;
  typedef logic [65:0]        fsum_t;
  typedef logic [64:0]        esum_t;
  typedef logic [81:0]        emag_t;

  // low part width when a projection is split for the edge products
  localparam int unsigned SplitW = 25;
  localparam comp_t AxisOne = 16'sd16384;
  localparam logic [14:0] CutoffReset = 15'd16383;

  // box after the center difference
  typedef struct packed {
    logic          valid;
    diff_t [2:0]   d;
    comp_t [8:0]   a;
    comp_t [8:0]   b;
    half_t [2:0]   ha;
    half_t [2:0]   hb;
  } box_st_t;

  // dot products
  typedef struct packed {
    logic          valid;
    proj_t [2:0]   ad;
    proj_t [2:0]   bd;
    dotc_t [8:0]   c;
    half_t [2:0]   ha;
    half_t [2:0]   hb;
  } dot_st_t;

  // magnitudes and parallel flag
  typedef struct packed {
    logic          valid;
    logic          par;
    proj_t [2:0]   ad;
    pmag_t [2:0]   adm;
    pmag_t [2:0]   bdm;
    dotc_t [8:0]   c;
    cmag_t [8:0]   ac;
    half_t [2:0]   ha;
    half_t [2:0]   hb;
  } mag_st_t;

  // products
  typedef struct packed {
    logic               valid;
    logic               par;
    pmag_t [2:0]        adm;
    pmag_t [2:0]        bdm;
    half_t [2:0]        ha;
    half_t [2:0]        hb;
    rprod_t [8:0]       fa;
    rprod_t [8:0]       fb;
    rprod_t [8:0][3:0]  er;
    lpart_t [8:0][3:0]  el;
  } prod_st_t;

  // face verdict and edge terms
  typedef struct packed {
    logic          valid;
    logic          par;
    logic          face_sep;
    eprod_t [8:0]  p1;
    eprod_t [8:0]  p2;
    esum_t [8:0]   es;
  } sum_st_t;

  function automatic int nxt(input int x);
    return (x == 2) ? 0 : x + 1;
  endfunction

endpackage

// ----- hw/rtl/obbov_if.sv -----
interface obbov_box_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [47:0]        axis_first;
  logic [47:0]        axis_second;
  logic [47:0]        axis_third;
  logic [30:0]        half_size_first;
  logic [30:0]        half_size_second;
  logic [30:0]        half_size_third;

  modport source (output valid, req_type, center_x, center_y, center_z, axis_first,
                  axis_second, axis_third, half_size_first, half_size_second,
                  half_size_third, input ready);
  modport sink (input valid, req_type, center_x, center_y, center_z, axis_first,
                axis_second, axis_third, half_size_first, half_size_second,
                half_size_third, output ready);
endinterface

interface obbov_verdict_if;
  logic valid;
  logic ready;
  logic boxes_overlap;

  modport source (output valid, boxes_overlap, input ready);
  modport sink (input valid, boxes_overlap, output ready);
endinterface

// ----- hw/rtl/obb_obb_overlap_test_core.sv -----
// channel   dir  handshake        payload
// box       in   valid / ready    req_type, center_x/y/z, axis_*, half_size_*
// verdict   out  valid / ready    boxes_overlap
// cfg       in   cfg_wr_en        cfg_wr_data (parallel_cutoff)
//
// one item per cycle while box.ready is high
// load items update the reference box at acceptance and give no result
// the seven register stages advance together; box.ready drops only while a
// result waits at the output, and nothing is lost or repeated
// rst clears the reference box to identity axes, zero center and extents
module obb_obb_overlap_test_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [14:0]      cfg_wr_data,
  obbov_box_if.sink        box,
  obbov_verdict_if.source  verdict
);
  import obbov_pkg::*;

  logic        en;
  logic [14:0] cutoff;
  box_st_t     s1;
  mag_st_t     s3;
  sum_st_t     s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CutoffReset;
    end else if (cfg_wr_en) begin
      cutoff <= cfg_wr_data;
    end
  end

  obbov_front u_front (
    .clk (clk), .rst (rst), .en (en), .box (box), .s1 (s1)
  );

  obbov_proj u_proj (
    .clk (clk), .rst (rst), .en (en), .cutoff (cutoff), .s1 (s1), .s3 (s3)
  );

  obbov_rad u_rad (
    .clk (clk), .rst (rst), .en (en), .s3 (s3), .s5 (s5)
  );

  obbov_decide u_decide (
    .clk (clk), .rst (rst), .en (en), .s5 (s5), .verdict (verdict)
  );

endmodule

// ----- hw/rtl/obbov_front.sv -----
module obbov_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  obbov_box_if.sink        box,
  output obbov_pkg::box_st_t s1
);
  import obbov_pkg::*;

  logic signed [31:0] ref_c [3];
  comp_t              ref_a [9];
  half_t              ref_h [3];
  logic signed [31:0] ctr [3];
  comp_t [8:0]        axes;
  box_st_t            s1_next;

  assign box.ready = en;

  always_comb begin
    ctr[0] = box.center_x;
    ctr[1] = box.center_y;
    ctr[2] = box.center_z;
    axes = {box.axis_third, box.axis_second, box.axis_first};
    s1_next.valid = box.valid && box.req_type;
    for (int k = 0; k < 3; k++) begin
      s1_next.d[k] = diff_t'(ctr[k]) - diff_t'(ref_c[k]);
      s1_next.ha[k] = ref_h[k];
    end
    for (int n = 0; n < 9; n++) begin
      s1_next.a[n] = ref_a[n];
    end
    s1_next.b = axes;
    s1_next.hb = {box.half_size_third, box.half_size_second, box.half_size_first};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        ref_c[k] <= '0;
        ref_h[k] <= '0;
      end
      for (int n = 0; n < 9; n++) begin
        ref_a[n] <= (n == 0 || n == 4 || n == 8) ? AxisOne : '0;
      end
    end else if (en) begin
      s1 <= s1_next;
      // load item replaces the reference box
      if (box.valid && !box.req_type) begin
        for (int k = 0; k < 3; k++) begin
          ref_c[k] <= ctr[k];
        end
        ref_h[0] <= box.half_size_first;
        ref_h[1] <= box.half_size_second;
        ref_h[2] <= box.half_size_third;
        for (int n = 0; n < 9; n++) begin
          ref_a[n] <= axes[n];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/obbov_proj.sv -----
module obbov_proj (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [14:0]        cutoff,
  input  obbov_pkg::box_st_t s1,
  output obbov_pkg::mag_st_t s3
);
  import obbov_pkg::*;

  dot_st_t s2, s2_next;
  mag_st_t s3_next;
  cmag_t   cut;

  always_comb begin
    s2_next = '0;
    s2_next.valid = s1.valid;
    s2_next.ha = s1.ha;
    s2_next.hb = s1.hb;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s2_next.ad[i] = s2_next.ad[i] + proj_t'(s1.a[3*i+k]) * proj_t'(s1.d[k]);
        s2_next.bd[i] = s2_next.bd[i] + proj_t'(s1.b[3*i+k]) * proj_t'(s1.d[k]);
      end
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          s2_next.c[3*i+j] = s2_next.c[3*i+j]
                             + dotc_t'(s1.a[3*i+k]) * dotc_t'(s1.b[3*j+k]);
        end
      end
    end
  end

  always_comb begin
    cut = {3'b000, cutoff, 14'b0};
    s3_next.valid = s2.valid;
    s3_next.par = 1'b0;
    s3_next.ad = s2.ad;
    s3_next.c = s2.c;
    s3_next.ha = s2.ha;
    s3_next.hb = s2.hb;
    for (int i = 0; i < 3; i++) begin
      s3_next.adm[i] = pmag_t'((s2.ad[i] < 0) ? -s2.ad[i] : s2.ad[i]);
      s3_next.bdm[i] = pmag_t'((s2.bd[i] < 0) ? -s2.bd[i] : s2.bd[i]);
    end
    for (int n = 0; n < 9; n++) begin
      s3_next.ac[n] = cmag_t'((s2.c[n] < 0) ? -s2.c[n] : s2.c[n]);
      if (s3_next.ac[n] > cut) s3_next.par = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (en) begin
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

endmodule

// ----- hw/rtl/obbov_rad.sv -----
module obbov_rad (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  obbov_pkg::mag_st_t s3,
  output obbov_pkg::sum_st_t s5
);
  import obbov_pkg::*;

  prod_st_t s4, s4_next;
  sum_st_t  s5_next;
  proj_t    x1, x2;
  fsum_t    rf, sf;
  esum_t    esum;

  always_comb begin
    x1 = '0;
    x2 = '0;
    s4_next.valid = s3.valid;
    s4_next.par = s3.par;
    s4_next.adm = s3.adm;
    s4_next.bdm = s3.bdm;
    s4_next.ha = s3.ha;
    s4_next.hb = s3.hb;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s4_next.fa[3*i+j] = rprod_t'(s3.hb[j]) * rprod_t'(s3.ac[3*i+j]);
        s4_next.fb[3*i+j] = rprod_t'(s3.ha[i]) * rprod_t'(s3.ac[3*i+j]);
        // edge axis A_i x B_j
        s4_next.er[3*i+j][0] = rprod_t'(s3.ha[nxt(i)]) * rprod_t'(s3.ac[3*nxt(nxt(i))+j]);
        s4_next.er[3*i+j][1] = rprod_t'(s3.ha[nxt(nxt(i))]) * rprod_t'(s3.ac[3*nxt(i)+j]);
        s4_next.er[3*i+j][2] = rprod_t'(s3.hb[nxt(j)]) * rprod_t'(s3.ac[3*i+nxt(nxt(j))]);
        s4_next.er[3*i+j][3] = rprod_t'(s3.hb[nxt(nxt(j))]) * rprod_t'(s3.ac[3*i+nxt(j)]);
        x1 = s3.ad[nxt(nxt(i))];
        x2 = s3.ad[nxt(i)];
        // projection split into signed high and unsigned low parts
        s4_next.el[3*i+j][0] = lpart_t'($signed(x1[49:SplitW]))
                               * lpart_t'(s3.c[3*nxt(i)+j]);
        s4_next.el[3*i+j][1] = lpart_t'($signed({1'b0, x1[SplitW-1:0]}))
                               * lpart_t'(s3.c[3*nxt(i)+j]);
        s4_next.el[3*i+j][2] = lpart_t'($signed(x2[49:SplitW]))
                               * lpart_t'(s3.c[3*nxt(nxt(i))+j]);
        s4_next.el[3*i+j][3] = lpart_t'($signed({1'b0, x2[SplitW-1:0]}))
                               * lpart_t'(s3.c[3*nxt(nxt(i))+j]);
      end
    end
  end

  always_comb begin
    rf = '0;
    sf = '0;
    esum = '0;
    s5_next.valid = s4.valid;
    s5_next.par = s4.par;
    s5_next.face_sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rf = fsum_t'({s4.adm[i], 14'b0});
      sf = fsum_t'({s4.ha[i], 28'b0}) + fsum_t'(s4.fa[3*i]) + fsum_t'(s4.fa[3*i+1])
           + fsum_t'(s4.fa[3*i+2]);
      if (rf > sf) s5_next.face_sep = 1'b1;
      rf = fsum_t'({s4.bdm[i], 14'b0});
      sf = fsum_t'({s4.hb[i], 28'b0}) + fsum_t'(s4.fb[i]) + fsum_t'(s4.fb[3+i])
           + fsum_t'(s4.fb[6+i]);
      if (rf > sf) s5_next.face_sep = 1'b1;
    end
    for (int e = 0; e < 9; e++) begin
      s5_next.p1[e] = (eprod_t'(s4.el[e][0]) <<< SplitW) + eprod_t'(s4.el[e][1]);
      s5_next.p2[e] = (eprod_t'(s4.el[e][2]) <<< SplitW) + eprod_t'(s4.el[e][3]);
      esum = esum_t'(s4.er[e][0]) + esum_t'(s4.er[e][1]) + esum_t'(s4.er[e][2])
             + esum_t'(s4.er[e][3]);
      s5_next.es[e] = esum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
    end else if (en) begin
      s4 <= s4_next;
      s5 <= s5_next;
    end
  end

endmodule

// ----- hw/rtl/obbov_decide.sv -----
module obbov_decide (
  input  logic               clk,
  input  logic               rst,
  output logic               en,
  input  obbov_pkg::sum_st_t s5,
  obbov_verdict_if.source    verdict
);
  import obbov_pkg::*;

  logic             v6, face6, par6;
  emag_t [8:0]      em6, em6_next;
  esum_t [8:0]      es6;
  logic signed [82:0] df;
  logic             edge_sep;
  logic             out_valid, out_bit;

  assign en = !out_valid || verdict.ready;
  assign verdict.valid = out_valid;
  assign verdict.boxes_overlap = out_bit;

  always_comb begin
    df = '0;
    for (int e = 0; e < 9; e++) begin
      df = 83'(s5.p1[e]) - 83'(s5.p2[e]);
      em6_next[e] = emag_t'((df < 0) ? -df : df);
    end
  end

  always_comb begin
    edge_sep = 1'b0;
    for (int e = 0; e < 9; e++) begin
      if (em6[e] > emag_t'({es6[e], 14'b0})) edge_sep = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v6 <= s5.valid;
      face6 <= s5.face_sep;
      par6 <= s5.par;
      em6 <= em6_next;
      es6 <= s5.es;
      out_valid <= v6;
      // near-parallel pairs skip the edge axes
      out_bit <= !face6 && (par6 || !edge_sep);
    end
  end

endmodule

// ----- hw/rtl/obbov_checker.sv -----
module obbov_checker (
  input logic clk,
  input logic rst,
  input logic box_ready,
  input logic out_valid,
  input logic out_ready,
  input logic boxes_overlap
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(boxes_overlap))
    else $error("result changed while stalled");

  // input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !box_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind obb_obb_overlap_test_core obbov_checker u_chk (
  .clk (clk),
  .rst (rst),
  .box_ready (box.ready),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .boxes_overlap (verdict.boxes_overlap)
);
